@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/alids_pkg.sv @@
// Types and codes for the array list block
package alids_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 4;

	// request kinds
	localparam logic [2:0] KIND_CREATE  = 3'd0;
	localparam logic [2:0] KIND_DISPLAY = 3'd1;
	localparam logic [2:0] KIND_INSERT  = 3'd2;
	localparam logic [2:0] KIND_DELETE  = 3'd3;
	localparam logic [2:0] KIND_SEARCH  = 3'd4;

	// result status
	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_NOT_CREATED = 2'd1;
	localparam logic [1:0] STAT_BAD_POS     = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND   = 2'd3;

	// cell operations
	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_CREATE = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [POS_W-1:0] pos0;   // 0-based target slot
	} cell_ctrl_t;

endpackage

@@ hdl/alids_cell.sv @@
// One slot of the list: holds a word, shifts with its neighbors, compares
module alids_cell import alids_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] prev_data,
	input  logic signed [DATA_W-1:0] next_data,
	output logic signed [DATA_W-1:0] data,
	output logic                     hit
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			OP_CREATE: data_d = DATA_W'(INDEX + 1);
			OP_INSERT: begin
				if (MY_POS > ctrl.pos0)
					data_d = prev_data;
				else if (MY_POS == ctrl.pos0)
					data_d = value;
			end
			OP_DELETE: begin
				if (MY_POS >= ctrl.pos0)
					data_d = next_data;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign hit  = (data_q == value);

endmodule

@@ hdl/array_list_insert_delete_search.sv @@
// Top level of the fixed-capacity array list
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  request | req_valid/req_stall  | kind, position, value
//  result  | rsp_valid/rsp_stall  | status, found_position, element, last
//
// A request is captured while idle and executed once the result register is free,
// so create, insert, delete and search each give one result; display gives one
// result per cycle out of the slot read mux while the result is not stalled.
// The slot shifts happen in the same cycle across the row of cells.
// Reset clears the count and the created flag; slot contents stay undefined.
// A stalled result holds execution of the next request but not its capture.
`include "assert_macros.svh"

module array_list_insert_delete_search import alids_pkg::*; #(
	parameter int CAPACITY = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [2:0]               kind,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [1:0]               status,
	output logic [POS_W-1:0]         found_position,
	output logic signed [DATA_W-1:0] element,
	output logic                     last
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [4:0] CAP5 = 5'(CAPACITY);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DISP = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic          created_q;
	logic [IW-1:0] idx_q;
	logic          valid_q;

	// captured request
	logic [2:0]               kind_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [DATA_W-1:0] value_q;

	// result register
	logic [1:0]               status_q;
	logic [POS_W-1:0]         found_q;
	logic signed [DATA_W-1:0] element_q;
	logic                     last_q;

	// cell row
	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]      cell_hit;
	cell_ctrl_t               ctrl;

	logic out_free;
	assign out_free = !valid_q || !rsp_stall;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic signed [DATA_W-1:0] prev_d;
			logic signed [DATA_W-1:0] next_d;
			if (g == 0) begin : g_first
				assign prev_d = '0;
			end else begin : g_mid
				assign prev_d = cell_data[g-1];
			end
			if (g == CAPACITY - 1) begin : g_end
				assign next_d = '0;
			end else begin : g_nxt
				assign next_d = cell_data[g+1];
			end
			alids_cell #(.INDEX(g)) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.value     (value_q),
				.prev_data (prev_d),
				.next_data (next_d),
				.data      (cell_data[g]),
				.hit       (cell_hit[g])
			);
		end
	endgenerate

	// first live slot that matches
	logic          hit_any;
	logic [IW-1:0] hit_idx;
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_hit[i] && (5'(i) < 5'(count_q))) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	// execute-stage decode
	logic [4:0]    pos5, cnt5, ins_lim;
	logic          exec_emit, exec_disp, exec_created;
	logic [1:0]    exec_status, exec_op;
	logic [POS_W-1:0] exec_found;
	logic [CW-1:0] exec_cnt;

	assign pos5    = 5'(pos_q);
	assign cnt5    = 5'(count_q);
	assign ins_lim = (cnt5 + 5'd1 > CAP5) ? CAP5 : cnt5 + 5'd1;

	always_comb begin
		exec_emit    = 1'b0;
		exec_disp    = 1'b0;
		exec_status  = STAT_OK;
		exec_found   = '0;
		exec_op      = OP_HOLD;
		exec_cnt     = count_q;
		exec_created = created_q;
		if (kind_q == KIND_CREATE) begin
			exec_emit    = 1'b1;
			exec_op      = OP_CREATE;
			exec_cnt     = CW'(CAPACITY);
			exec_created = 1'b1;
		end else if (kind_q <= KIND_SEARCH) begin
			exec_emit = 1'b1;
			if (!created_q) begin
				exec_status = STAT_NOT_CREATED;
			end else begin
				case (kind_q)
					KIND_DISPLAY: begin
						if (count_q != '0) begin
							exec_emit = 1'b0;
							exec_disp = 1'b1;
						end
					end
					KIND_INSERT: begin
						if (pos5 == 5'd0 || pos5 > ins_lim) begin
							exec_status = STAT_BAD_POS;
						end else begin
							exec_op = OP_INSERT;
							if (cnt5 < CAP5)
								exec_cnt = count_q + CW'(1);
						end
					end
					KIND_DELETE: begin
						if (pos5 == 5'd0 || pos5 > cnt5) begin
							exec_status = STAT_BAD_POS;
						end else begin
							exec_op  = OP_DELETE;
							exec_cnt = count_q - CW'(1);
						end
					end
					KIND_SEARCH: begin
						if (hit_any)
							exec_found = POS_W'(hit_idx) + POS_W'(1);
						else
							exec_status = STAT_NOT_FOUND;
					end
					default: exec_emit = 1'b0;
				endcase
			end
		end
	end

	assign ctrl.op   = (state_q == S_EXEC && out_free) ? exec_op : OP_HOLD;
	assign ctrl.pos0 = pos_q - POS_W'(1);

	logic disp_last;
	assign disp_last = (CW'(idx_q) + CW'(1)) == count_q;

	// result valid: held while stalled, set when a new result is loaded
	logic valid_d;
	always_comb begin
		valid_d = valid_q && rsp_stall;
		if (state_q == S_EXEC && out_free && exec_emit)
			valid_d = 1'b1;
		else if (state_q == S_DISP && out_free)
			valid_d = 1'b1;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			created_q <= 1'b0;
			idx_q     <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= valid_d;
			case (state_q)
				S_IDLE: begin
					if (req_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						count_q   <= exec_cnt;
						created_q <= exec_created;
						idx_q     <= '0;
						state_q   <= exec_disp ? S_DISP : S_IDLE;
					end
				end
				S_DISP: begin
					if (out_free) begin
						if (disp_last)
							state_q <= S_IDLE;
						else
							idx_q <= idx_q + IW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			kind_q  <= kind;
			pos_q   <= position;
			value_q <= value;
		end
		if (state_q == S_EXEC && out_free && exec_emit) begin
			status_q  <= exec_status;
			found_q   <= exec_found;
			element_q <= '0;
			last_q    <= 1'b1;
		end else if (state_q == S_DISP && out_free) begin
			status_q  <= STAT_OK;
			found_q   <= POS_W'(idx_q) + POS_W'(1);
			element_q <= cell_data[idx_q];
			last_q    <= disp_last;
		end
	end

	assign req_stall      = (state_q != S_IDLE);
	assign rsp_valid      = valid_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign element        = element_q;
	assign last           = last_q;

	// checks
	`ASSERT_IMPLIES(a_count_cap, clk, arst_n, 1'b1, 5'(count_q) <= CAP5)
	`ASSERT_IMPLIES(a_mid_disp, clk, arst_n, rsp_valid && !last, state_q == S_DISP)
	`ASSERT_IMPLIES(a_not_created, clk, arst_n,
		rsp_valid && status == STAT_NOT_CREATED, !created_q)
	`ASSERT_IMPLIES(a_found_live, clk, arst_n,
		rsp_valid && status == STAT_OK, 5'(found_position) <= 5'(count_q))
	`ASSERT_NEXT(a_exec_after_take, clk, arst_n,
		state_q == S_IDLE && req_valid, state_q == S_EXEC)

endmodule
